### rtl/core/tcee_pkg.sv
// ----------------------------------------------------------------------------
// tcee_pkg
// Shared types, byte codes and lookup tables for the terminal cell escape
// encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tcee_pkg;

  localparam int SLOTS            = 18;
  localparam int DEC_W            = 17;
  localparam int MAX_DIGITS       = 5;
  localparam int DIGIT_IDX_W      = $clog2(MAX_DIGITS);
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 2;
  localparam int FRAME_TABLE_SIZE = 48;
  localparam int FRAME_IDX_W      = 6;

  localparam logic [7:0] FRAME_BASE = 8'd176;
  localparam logic [7:0] FRAME_END  = 8'(176 + FRAME_TABLE_SIZE);

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SO    = 8'h0e;
  localparam logic [7:0] CH_SI    = 8'h0f;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  localparam logic [1:0] MODE_UNKNOWN = 2'd2;
  localparam logic [7:0] ATTR_UNKNOWN = 8'h80;

  typedef enum logic [1:0] {
    CMD_PRINT     = 2'd0,
    CMD_CURSOR    = 2'd1,
    CMD_FRAME_END = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    TTY_LINUX = 2'd0,
    TTY_VT100 = 2'd1,
    TTY_KOI8  = 2'd2,
    TTY_DUMB  = 2'd3
  } term_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TERMINAL_TYPE = 3'd0,
    REG_CHARSET_HACK  = 3'd1,
    REG_COLOR         = 3'd2,
    REG_RESTRICT      = 3'd3,
    REG_TRANSPARENCY  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } fe_state_t;

  typedef struct packed {
    term_t term;
    logic  charset_hack;
    logic  color;
    logic  restrict_frames;
    logic  transparency;
  } cfg_t;

  // one queued job: fixed byte slots, sent in slot order where the mask is set
  typedef struct packed {
    logic [SLOTS-1:0]      mask;
    logic [SLOTS-1:0][7:0] bytes;
  } job_t;

  typedef struct packed {
    logic [3:0]       digit;
    logic [DEC_W-1:0] rem;
  } dec_step_t;

  localparam logic [0:FRAME_TABLE_SIZE-1][7:0] TAB_DUMB =
    "   ||||++||++++++--|-+||++--|-+----++++++++     ";
  localparam logic [0:FRAME_TABLE_SIZE-1][7:0] TAB_VT100 =
    "aaaxuuukkuxkjjjkmvwtqnttmlvwtqnvvwwmmllnnjla    ";
  localparam logic [0:FRAME_TABLE_SIZE-1][7:0] TAB_KOI = {
    8'd144, 8'd145, 8'd146, 8'd129, 8'd135, 8'd178, 8'd180, 8'd167,
    8'd166, 8'd181, 8'd161, 8'd168, 8'd174, 8'd173, 8'd172, 8'd131,
    8'd132, 8'd137, 8'd136, 8'd134, 8'd128, 8'd138, 8'd175, 8'd176,
    8'd171, 8'd165, 8'd187, 8'd184, 8'd177, 8'd160, 8'd190, 8'd185,
    8'd186, 8'd182, 8'd183, 8'd170, 8'd169, 8'd162, 8'd164, 8'd189,
    8'd188, 8'd133, 8'd130, 8'd141, 8'd140, 8'd142, 8'd143, 8'd139
  };
  localparam logic [0:FRAME_TABLE_SIZE-1][7:0] TAB_RESTRICT = {
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd179, 8'd186, 8'd186,
    8'd205, 8'd0,   8'd0,   8'd0,   8'd0,   8'd186, 8'd205, 8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd179, 8'd186,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd205,
    8'd196, 8'd205, 8'd196, 8'd186, 8'd205, 8'd205, 8'd186, 8'd186,
    8'd179, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };

  function automatic logic [7:0] tab_lookup(
    input logic [0:FRAME_TABLE_SIZE-1][7:0] tab,
    input logic [FRAME_IDX_W-1:0]           idx
  );
    if (idx < FRAME_IDX_W'(FRAME_TABLE_SIZE)) return tab[idx];
    return 8'h00;
  endfunction

  function automatic logic [2:0] rot3(input logic [2:0] c);
    return {c[1:0], c[2]};
  endfunction

  function automatic logic [DEC_W-1:0] pow10(input logic [DIGIT_IDX_W-1:0] k);
    logic [DEC_W-1:0] p;
    unique case (k)
      3'd0:    p = DEC_W'(1);
      3'd1:    p = DEC_W'(10);
      3'd2:    p = DEC_W'(100);
      3'd3:    p = DEC_W'(1000);
      default: p = DEC_W'(10000);
    endcase
    return p;
  endfunction

  // one decimal digit of v at position k, by compare against its nine multiples
  function automatic dec_step_t dec_step(
    input logic [DEC_W-1:0]       v,
    input logic [DIGIT_IDX_W-1:0] k
  );
    logic [DEC_W+3:0] p;
    logic [DEC_W+3:0] thr;
    dec_step_t        r;
    p       = {4'b0, pow10(k)};
    r.digit = 4'd0;
    r.rem   = v;
    for (int m = 1; m <= 9; m++) begin
      thr = p * (DEC_W + 4)'(m);
      if ({4'b0, v} >= thr) begin
        r.digit = 4'(m);
        r.rem   = DEC_W'({4'b0, v} - thr);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tcee_queue.sv
// ----------------------------------------------------------------------------
// tcee_queue
// Short job queue between the classifying front end and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module tcee_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  tcee_pkg::job_t     wr_data,
  output logic               q_full,
  input  wire logic          rd_en,
  output tcee_pkg::job_t     rd_data,
  output logic               q_valid
);

  tcee_pkg::job_t                     entries [tcee_pkg::QUEUE_DEPTH];
  logic [tcee_pkg::QPTR_W-1:0]        wr_ptr;
  logic [tcee_pkg::QPTR_W-1:0]        rd_ptr;
  logic [tcee_pkg::QCNT_W-1:0]        count;

  assign q_full  = count == tcee_pkg::QCNT_W'(tcee_pkg::QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + tcee_pkg::QPTR_W'(1);
      if (rd_en) rd_ptr <= rd_ptr + tcee_pkg::QPTR_W'(1);
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + tcee_pkg::QCNT_W'(1);
        2'b01:   count <= count - tcee_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) entries[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

### rtl/core/tcee_front.sv
// ----------------------------------------------------------------------------
// tcee_front
// Accepts commands, tracks charset mode and attribute, and builds byte jobs;
// cursor coordinates go through a digit-per-cycle decimal converter.
// ----------------------------------------------------------------------------
`default_nettype none

module tcee_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  tcee_pkg::cfg_t                   cfg,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [1:0]                  cmd,
  input  wire logic [7:0]                  cell_char,
  input  wire logic [6:0]                  cell_attrib,
  input  wire logic                        cell_frame,
  input  wire logic [tcee_pkg::DEC_W-1:0]  row_val,
  input  wire logic [tcee_pkg::DEC_W-1:0]  col_val,
  output logic                             q_push,
  output tcee_pkg::job_t                   q_data,
  input  wire logic                        q_full
);

  localparam int ROW_SLOT  = 2;
  localparam int SEP_SLOT  = ROW_SLOT + tcee_pkg::MAX_DIGITS;
  localparam int COL_SLOT  = SEP_SLOT + 1;
  localparam int END_SLOT  = COL_SLOT + tcee_pkg::MAX_DIGITS;

  tcee_pkg::fe_state_t state;
  tcee_pkg::fe_state_t state_next;

  logic [1:0] charset_mode;
  logic [7:0] prev_attr;
  logic       frame_has_output;

  logic [tcee_pkg::DIGIT_IDX_W-1:0]       k;
  logic [tcee_pkg::DEC_W-1:0]             row_rem;
  logic [tcee_pkg::DEC_W-1:0]             col_rem;
  logic [tcee_pkg::MAX_DIGITS-1:0][7:0]   row_dig;
  logic [tcee_pkg::MAX_DIGITS-1:0][7:0]   col_dig;
  logic [tcee_pkg::MAX_DIGITS-1:0]        row_en;
  logic [tcee_pkg::MAX_DIGITS-1:0]        col_en;
  logic                                   row_seen;
  logic                                   col_seen;

  logic accept;

  // print cell classification
  logic                             in_frame;
  logic [tcee_pkg::FRAME_IDX_W-1:0] idx;
  logic                             mode_chg;
  logic                             set_mode;
  logic [7:0]                       ch;
  logic [7:0]                       rmap;
  logic [6:0]                       an;
  logic                             sgr;
  tcee_pkg::job_t                   pj;
  tcee_pkg::job_t                   tj;
  tcee_pkg::job_t                   cj;
  tcee_pkg::dec_step_t              rs;
  tcee_pkg::dec_step_t              cs;

  always_comb begin
    idx      = tcee_pkg::FRAME_IDX_W'(cell_char - tcee_pkg::FRAME_BASE);
    in_frame = cell_frame && cell_char >= tcee_pkg::FRAME_BASE
               && cell_char < tcee_pkg::FRAME_END;
    rmap     = tcee_pkg::tab_lookup(tcee_pkg::TAB_RESTRICT, idx);
    mode_chg = {1'b0, cell_frame} != charset_mode;
    set_mode = 1'b0;
    ch       = cell_char;
    pj       = '0;

    unique case (cfg.term)
      tcee_pkg::TTY_LINUX: begin
        if (cfg.charset_hack && mode_chg) begin
          set_mode    = 1'b1;
          pj.mask[4:0] = 5'b11111;
          pj.bytes[0] = tcee_pkg::CH_ESC;
          pj.bytes[1] = tcee_pkg::CH_LBR;
          pj.bytes[2] = tcee_pkg::CH_ONE;
          pj.bytes[3] = cell_frame ? tcee_pkg::CH_ONE : tcee_pkg::CH_ZERO;
          pj.bytes[4] = tcee_pkg::CH_M;
        end
        if (cfg.restrict_frames && in_frame && rmap != 8'h00) ch = rmap;
      end
      tcee_pkg::TTY_VT100: begin
        if (mode_chg) begin
          set_mode    = 1'b1;
          pj.mask[0]  = 1'b1;
          pj.bytes[0] = cell_frame ? tcee_pkg::CH_SO : tcee_pkg::CH_SI;
        end
        if (in_frame) ch = tcee_pkg::tab_lookup(tcee_pkg::TAB_VT100, idx);
      end
      tcee_pkg::TTY_KOI8: begin
        if (in_frame) ch = tcee_pkg::tab_lookup(tcee_pkg::TAB_KOI, idx);
      end
      tcee_pkg::TTY_DUMB: begin
        if (in_frame) ch = tcee_pkg::tab_lookup(tcee_pkg::TAB_DUMB, idx);
      end
      default: ch = cell_char;
    endcase

    // equal colours without bold keep the background and get a black or white foreground
    an = cell_attrib;
    if (!cell_attrib[6] && cell_attrib[5:3] == cell_attrib[2:0]) begin
      an = {1'b0, cell_attrib[5:3], cell_attrib[4] ? 3'd0 : 3'd7};
    end
    sgr = {1'b0, an} != prev_attr;

    if (sgr) begin
      pj.mask[7:5] = 3'b111;
      pj.bytes[5]  = tcee_pkg::CH_ESC;
      pj.bytes[6]  = tcee_pkg::CH_LBR;
      pj.bytes[7]  = tcee_pkg::CH_ZERO;
      if (cfg.color) begin
        pj.mask[10:8] = 3'b111;
        pj.bytes[8]   = tcee_pkg::CH_SEMI;
        pj.bytes[9]   = tcee_pkg::CH_THREE;
        pj.bytes[10]  = tcee_pkg::CH_ZERO + {5'b0, an[2:0]};
        if (!cfg.transparency || an[5:3] != 3'd0) begin
          pj.mask[13:11] = 3'b111;
          pj.bytes[11]   = tcee_pkg::CH_SEMI;
          pj.bytes[12]   = tcee_pkg::CH_FOUR;
          pj.bytes[13]   = tcee_pkg::CH_ZERO + {5'b0, an[5:3]};
        end
      end else if (tcee_pkg::rot3(an[2:0]) < tcee_pkg::rot3(an[5:3])) begin
        pj.mask[9:8] = 2'b11;
        pj.bytes[8]  = tcee_pkg::CH_SEMI;
        pj.bytes[9]  = tcee_pkg::CH_SEVEN;
      end
      if (an[6]) begin
        pj.mask[15:14] = 2'b11;
        pj.bytes[14]   = tcee_pkg::CH_SEMI;
        pj.bytes[15]   = tcee_pkg::CH_ONE;
      end
      pj.mask[16]  = 1'b1;
      pj.bytes[16] = tcee_pkg::CH_M;
    end

    pj.mask[17] = 1'b1;
    if (ch >= tcee_pkg::CH_SPACE && ch != tcee_pkg::CH_DEL) pj.bytes[17] = ch;
    else if (ch == 8'd0 || ch == 8'd1)                      pj.bytes[17] = tcee_pkg::CH_SPACE;
    else                                                    pj.bytes[17] = tcee_pkg::CH_DOT;
  end

  // frame trailer
  always_comb begin
    tj = '0;
    if (cfg.color) begin
      tj.mask[7:0] = 8'hff;
      tj.bytes[0]  = tcee_pkg::CH_ESC;
      tj.bytes[1]  = tcee_pkg::CH_LBR;
      tj.bytes[2]  = tcee_pkg::CH_THREE;
      tj.bytes[3]  = tcee_pkg::CH_SEVEN;
      tj.bytes[4]  = tcee_pkg::CH_SEMI;
      tj.bytes[5]  = tcee_pkg::CH_FOUR;
      tj.bytes[6]  = tcee_pkg::CH_ZERO;
      tj.bytes[7]  = tcee_pkg::CH_M;
    end
    tj.mask[11:8] = 4'hf;
    tj.bytes[8]   = tcee_pkg::CH_ESC;
    tj.bytes[9]   = tcee_pkg::CH_LBR;
    tj.bytes[10]  = tcee_pkg::CH_ZERO;
    tj.bytes[11]  = tcee_pkg::CH_M;
    if (cfg.term == tcee_pkg::TTY_LINUX && cfg.charset_hack) begin
      tj.mask[16:12] = 5'b11111;
      tj.bytes[12]   = tcee_pkg::CH_ESC;
      tj.bytes[13]   = tcee_pkg::CH_LBR;
      tj.bytes[14]   = tcee_pkg::CH_ONE;
      tj.bytes[15]   = tcee_pkg::CH_ZERO;
      tj.bytes[16]   = tcee_pkg::CH_M;
    end
    if (cfg.term == tcee_pkg::TTY_VT100) begin
      tj.mask[12]  = 1'b1;
      tj.bytes[12] = tcee_pkg::CH_SI;
    end
  end

  // cursor move from converted digits
  always_comb begin
    cj                 = '0;
    cj.mask[1:0]       = 2'b11;
    cj.bytes[0]        = tcee_pkg::CH_ESC;
    cj.bytes[1]        = tcee_pkg::CH_LBR;
    for (int d = 0; d < tcee_pkg::MAX_DIGITS; d++) begin
      cj.mask[ROW_SLOT + tcee_pkg::MAX_DIGITS - 1 - d]  = row_en[d];
      cj.bytes[ROW_SLOT + tcee_pkg::MAX_DIGITS - 1 - d] = row_dig[d];
      cj.mask[COL_SLOT + tcee_pkg::MAX_DIGITS - 1 - d]  = col_en[d];
      cj.bytes[COL_SLOT + tcee_pkg::MAX_DIGITS - 1 - d] = col_dig[d];
    end
    cj.mask[SEP_SLOT]  = 1'b1;
    cj.bytes[SEP_SLOT] = tcee_pkg::CH_SEMI;
    cj.mask[END_SLOT]  = 1'b1;
    cj.bytes[END_SLOT] = tcee_pkg::CH_H;
  end

  assign rs = tcee_pkg::dec_step(row_rem, k);
  assign cs = tcee_pkg::dec_step(col_rem, k);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcee_pkg::FE_IDLE: begin
        if (accept && cmd == tcee_pkg::CMD_CURSOR) state_next = tcee_pkg::FE_CONV;
      end
      tcee_pkg::FE_CONV: begin
        if (k == '0) state_next = tcee_pkg::FE_PUSH;
      end
      tcee_pkg::FE_PUSH: begin
        if (!q_full) state_next = tcee_pkg::FE_IDLE;
      end
      default: state_next = tcee_pkg::FE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full   = state != tcee_pkg::FE_IDLE || q_full;
    accept = push && !full;
    q_push = 1'b0;
    q_data = pj;
    unique case (state)
      tcee_pkg::FE_IDLE: begin
        q_push = accept && (cmd == tcee_pkg::CMD_PRINT
                 || (cmd == tcee_pkg::CMD_FRAME_END && frame_has_output));
        q_data = (cmd == tcee_pkg::CMD_PRINT) ? pj : tj;
      end
      tcee_pkg::FE_PUSH: begin
        q_push = !q_full;
        q_data = cj;
      end
      default: q_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= tcee_pkg::FE_IDLE;
      charset_mode     <= tcee_pkg::MODE_UNKNOWN;
      prev_attr        <= tcee_pkg::ATTR_UNKNOWN;
      frame_has_output <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        unique case (cmd)
          tcee_pkg::CMD_PRINT: begin
            if (set_mode) charset_mode <= {1'b0, cell_frame};
            prev_attr        <= {1'b0, an};
            frame_has_output <= 1'b1;
          end
          tcee_pkg::CMD_CURSOR: begin
            frame_has_output <= 1'b1;
          end
          tcee_pkg::CMD_FRAME_END: begin
            charset_mode     <= tcee_pkg::MODE_UNKNOWN;
            prev_attr        <= tcee_pkg::ATTR_UNKNOWN;
            frame_has_output <= 1'b0;
          end
          default: prev_attr <= prev_attr;
        endcase
      end
    end
  end

  // decimal converter, most significant digit first
  always_ff @(posedge clk) begin
    if (state == tcee_pkg::FE_IDLE && accept && cmd == tcee_pkg::CMD_CURSOR) begin
      row_rem  <= row_val;
      col_rem  <= col_val;
      k        <= tcee_pkg::DIGIT_IDX_W'(tcee_pkg::MAX_DIGITS - 1);
      row_seen <= 1'b0;
      col_seen <= 1'b0;
    end else if (state == tcee_pkg::FE_CONV) begin
      row_rem    <= rs.rem;
      col_rem    <= cs.rem;
      row_dig[k] <= tcee_pkg::CH_ZERO + {4'b0, rs.digit};
      col_dig[k] <= tcee_pkg::CH_ZERO + {4'b0, cs.digit};
      row_en[k]  <= row_seen || rs.digit != 4'd0 || k == '0;
      col_en[k]  <= col_seen || cs.digit != 4'd0 || k == '0;
      row_seen   <= row_seen || rs.digit != 4'd0;
      col_seen   <= col_seen || cs.digit != 4'd0;
      k          <= k - tcee_pkg::DIGIT_IDX_W'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/core/tcee_back.sv
// ----------------------------------------------------------------------------
// tcee_back
// Byte serializer: walks the set slots of each job in order and presents
// one byte per cycle through an output register while the consumer keeps popping.
// ----------------------------------------------------------------------------
`default_nettype none

module tcee_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  tcee_pkg::job_t   q_data,
  output logic             q_pop,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             last
);

  tcee_pkg::job_t                cur;
  logic                          cur_valid;
  logic                          out_valid;
  logic [tcee_pkg::SLOTS-1:0]    low;
  logic [tcee_pkg::SLOTS-1:0]    rest;
  logic [7:0]                    sel;
  logic                          emit;
  logic                          done;

  always_comb begin
    low  = cur.mask & (~cur.mask + tcee_pkg::SLOTS'(1));
    rest = cur.mask & ~low;
    sel  = 8'h00;
    for (int i = 0; i < tcee_pkg::SLOTS; i++) begin
      if (low[i]) sel = sel | cur.bytes[i];
    end
    emit  = cur_valid && (!out_valid || pop);
    done  = emit && rest == '0;
    q_pop = q_valid && (!cur_valid || done);
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop)     cur_valid <= 1'b1;
      else if (done) cur_valid <= 1'b0;
      if (emit)      out_valid <= 1'b1;
      else if (pop)  out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop)     cur      <= q_data;
    else if (emit) cur.mask <= rest;
    if (emit) begin
      out_byte <= sel;
      last     <= rest == '0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/terminal_cell_escape_encoder.sv
// ----------------------------------------------------------------------------
// terminal_cell_escape_encoder
// Turns screen cell, cursor and end-of-frame commands into a terminal byte
// stream with charset shifts, SGR attribute sequences and cursor moves.
// ----------------------------------------------------------------------------
// The output side sends one byte per cycle while the consumer keeps popping.
// An item causes one byte for a plain cell, up to 18 for a cell that
// switches charset and attribute, up to 17 for a frame trailer. A print or
// end-of-frame command is taken whenever the converter is idle and the
// two-entry job queue has room; it then passes through the queue and the
// serializer's job and output registers. A cursor command holds full high
// while the decimal converter produces one digit of row and column per
// cycle (five digit steps) and until its job is written to the queue. There
// is no clearing pass after reset. The config port is always ready.
`default_nettype none

module terminal_cell_escape_encoder #(
  parameter int COORD_WIDTH = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [1:0]                         cmd,
  input  wire logic [7:0]                         cell_char,
  input  wire logic [6:0]                         cell_attrib,
  input  wire logic                               cell_frame,
  input  wire logic [COORD_WIDTH-1:0]             row,
  input  wire logic [COORD_WIDTH-1:0]             col,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [7:0]                              out_byte,
  output logic                                    last,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tcee_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tcee_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tcee_pkg::cfg_t               cfg;
  logic [tcee_pkg::DEC_W-1:0]   row_val;
  logic [tcee_pkg::DEC_W-1:0]   col_val;
  logic                         q_push;
  tcee_pkg::job_t               q_wdata;
  logic                         q_full;
  logic                         q_pop;
  tcee_pkg::job_t               q_rdata;
  logic                         q_valid;

  assign cfg_ready = 1'b1;

  // one-based coordinates
  assign row_val = tcee_pkg::DEC_W'(row) + tcee_pkg::DEC_W'(1);
  assign col_val = tcee_pkg::DEC_W'(col) + tcee_pkg::DEC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{term: tcee_pkg::TTY_DUMB, default: '0};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcee_pkg::REG_TERMINAL_TYPE: cfg.term            <= tcee_pkg::term_t'(cfg_data);
        tcee_pkg::REG_CHARSET_HACK:  cfg.charset_hack    <= cfg_data[0];
        tcee_pkg::REG_COLOR:         cfg.color           <= cfg_data[0];
        tcee_pkg::REG_RESTRICT:      cfg.restrict_frames <= cfg_data[0];
        tcee_pkg::REG_TRANSPARENCY:  cfg.transparency    <= cfg_data[0];
        default:                     cfg                 <= cfg;
      endcase
    end
  end

  tcee_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .cell_char   (cell_char),
    .cell_attrib (cell_attrib),
    .cell_frame  (cell_frame),
    .row_val     (row_val),
    .col_val     (col_val),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .q_full      (q_full)
  );

  tcee_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_valid (q_valid)
  );

  tcee_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && !q_valid))
    else $error("job queue read while empty");

  a_print_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full && cmd == tcee_pkg::CMD_PRINT) |=> q_valid)
    else $error("accepted print transaction missing from job queue");

endmodule

`default_nettype wire
